>>> src/pcsl_pkg.sv
// Shared types and constants for the per-channel slew limiter.
// Used by the serial divider and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcsl_pkg;

    localparam int CH_W      = 3;
    localparam int VAL_W     = 12;
    localparam int POS_W     = 16;
    localparam int SUM_W     = 18;
    localparam int DLY_W     = 8;
    localparam int CFG_W     = 64;
    localparam int DIVISOR_W = 15;
    localparam int DELAY_SCALE = 100;

    // Division by ten through a reciprocal; exact for magnitudes below 32768.
    localparam int MAG_W        = 15;
    localparam int RECIP_W      = 16;
    localparam int PROD_W       = MAG_W + RECIP_W + 1;
    localparam int RECIP_SHIFT  = 19;
    localparam logic [RECIP_W-1:0] RECIP_10 = 16'd52429;

    localparam logic REG_RISE = 1'b0;
    localparam logic REG_FALL = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

>>> src/pcsl_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on pcsl_pkg for the divisor width and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module pcsl_div
    import pcsl_pkg::*;
#(
    parameter int DIVIDEND_W = 20
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic      [DIVIDEND_W-1:0] quotient,
    output div_stat_t                  stat
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_sub;
    logic                  fits;
    logic [DIVIDEND_W:0]   quo_shift;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        trial_sub = trial - {1'b0, dvs_reg};
        quo_shift = {quo_reg, fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_shift[DIVIDEND_W-1:0];
            rem_reg <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

>>> src/per_channel_slew_limiter.sv
// Per-channel slew limiter: top level with the position store and control.
// Depends on pcsl_pkg and the serial divider pcsl_div.
//
// Usage: each input beat carries a channel index and a signed target in
// tenths of a percent; each produces exactly one output beat with the
// channel index and the rate-limited position. Both channels use a
// valid/stall handshake. The block holds one item at a time: in_stall is
// high from acceptance until the result is moved to the output register.
// A move that is rate limited runs the step divider, one quotient bit per
// cycle, for K_W quotient bits (20 with the default parameters), passing
// through DECIDE, DIV, SCALE, ROUND and DONE. A jump to the target skips
// the divider (DECIDE, SCALE, ROUND, DONE); an absent channel goes from
// DECIDE straight to DONE.
// The output register lets the next beat be accepted while a result waits;
// while out_stall is high the result is held and, once the next result is
// ready too, in_stall stays high. Reset clears all positions and both delay
// registers to zero. Delay registers are written through cfg_we/cfg_index/
// cfg_data and should only change while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module per_channel_slew_limiter
    import pcsl_pkg::*;
#(
    parameter int CHANNELS  = 8,
    parameter int VALUE_MAX = 1250,
    parameter int FRAME_US  = 22500,
    parameter int DELAY_MAX = 100
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [CH_W-1:0]         channel,
    input  wire logic signed [VAL_W-1:0] target_value,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [CH_W-1:0]              out_channel,
    output logic signed [VAL_W-1:0]      limited_value
);

    localparam longint K_VAL = (longint'(2 * VALUE_MAX) * 10 * FRAME_US) / 1000;
    localparam int     K_W   = $clog2(K_VAL + 1);
    localparam logic [K_W-1:0]  K_CONST  = K_W'(K_VAL);
    localparam logic [CH_W:0]   CH_LIMIT = (CH_W + 1)'(CHANNELS);
    localparam logic [DLY_W-1:0] DLY_SAT = DLY_W'(DELAY_MAX);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_SCALE  = 3'd3;
    localparam logic [2:0] S_ROUND  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [CFG_W-1:0]         rise_reg;
    logic [CFG_W-1:0]         fall_reg;
    logic signed [POS_W-1:0]  pos_mem_reg [CHANNELS];
    logic [CH_W-1:0]          ch_reg;
    logic signed [VAL_W-1:0]  tgt_reg;
    logic                     up_reg;
    logic signed [POS_W-1:0]  newpos_reg;
    logic                     neg_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [VAL_W-1:0]  res_reg;
    logic                     out_valid_reg;
    logic [CH_W-1:0]          out_ch_reg;
    logic signed [VAL_W-1:0]  out_val_reg;

    logic                     in_accept;
    logic                     ch_ok;
    logic signed [POS_W-1:0]  tgt_ext;
    logic signed [POS_W-1:0]  t10;
    logic signed [POS_W-1:0]  cur_pos;
    logic [DLY_W-1:0]         rise_raw;
    logic [DLY_W-1:0]         fall_raw;
    logic [DLY_W-1:0]         rise_dly;
    logic [DLY_W-1:0]         fall_dly;
    logic                     go_up;
    logic                     go_down;
    logic [DIVISOR_W-1:0]     divisor;
    logic                     div_start;
    logic [K_W-1:0]           quotient;
    div_stat_t                div_stat;
    logic signed [SUM_W-1:0]  step;
    logic signed [SUM_W-1:0]  pos_ext;
    logic signed [SUM_W-1:0]  t10_ext;
    logic signed [SUM_W-1:0]  sum_up;
    logic signed [SUM_W-1:0]  sum_down;
    logic signed [POS_W-1:0]  clamped;
    logic [POS_W-1:0]         mag_full;
    logic [VAL_W-1:0]         quot10;
    logic                     out_load;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = state_reg != S_IDLE;

    always_comb
    begin
        ch_ok    = {1'b0, ch_reg} < CH_LIMIT;
        tgt_ext  = {{(POS_W - VAL_W){tgt_reg[VAL_W-1]}}, tgt_reg};
        t10      = (tgt_ext <<< 3) + (tgt_ext <<< 1);
        cur_pos  = pos_mem_reg[ch_reg];
        rise_raw = rise_reg[{ch_reg, 3'b000} +: DLY_W];
        fall_raw = fall_reg[{ch_reg, 3'b000} +: DLY_W];
        rise_dly = (rise_raw > DLY_SAT) ? DLY_SAT : rise_raw;
        fall_dly = (fall_raw > DLY_SAT) ? DLY_SAT : fall_raw;
        go_up    = (rise_dly != '0) && (t10 > cur_pos);
        go_down  = !go_up && (fall_dly != '0) && (t10 < cur_pos);
        divisor  = {{(DIVISOR_W - DLY_W){1'b0}}, (go_up ? rise_dly : fall_dly)}
                   * DIVISOR_W'(DELAY_SCALE);
        div_start = (state_reg == S_DECIDE) && ch_ok && (go_up || go_down);
    end

    pcsl_div #(
        .DIVIDEND_W (K_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (K_CONST),
        .divisor  (divisor),
        .quotient (quotient),
        .stat     (div_stat)
    );

    // Step the position toward the target and never past it; also form the magnitude, its tenth and the output load.
    always_comb
    begin
        step     = SUM_W'(quotient);
        pos_ext  = {{(SUM_W - POS_W){cur_pos[POS_W-1]}}, cur_pos};
        t10_ext  = {{(SUM_W - POS_W){t10[POS_W-1]}}, t10};
        sum_up   = pos_ext + step;
        sum_down = pos_ext - step;
        if (up_reg)
        begin
            clamped = (sum_up > t10_ext) ? t10 : sum_up[POS_W-1:0];
        end
        else
        begin
            clamped = (sum_down < t10_ext) ? t10 : sum_down[POS_W-1:0];
        end
        mag_full = newpos_reg[POS_W-1] ? -newpos_reg : newpos_reg;
        quot10   = prod_reg[RECIP_SHIFT +: VAL_W];
        out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!ch_ok)
                begin
                    state_next = S_DONE;
                end
                else if (go_up || go_down)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_SCALE;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rise_reg      <= '0;
            fall_reg      <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                pos_mem_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RISE: rise_reg <= cfg_data;
                    REG_FALL: fall_reg <= cfg_data;
                    default:  rise_reg <= rise_reg;
                endcase
            end
            if (state_reg == S_SCALE)
            begin
                pos_mem_reg[ch_reg] <= newpos_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ch_reg  <= channel;
            tgt_reg <= target_value;
        end
        case (state_reg)
            S_DECIDE:
            begin
                up_reg     <= go_up;
                newpos_reg <= t10;
                res_reg    <= tgt_reg;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    newpos_reg <= clamped;
                end
            end
            S_SCALE:
            begin
                neg_reg  <= newpos_reg[POS_W-1];
                prod_reg <= PROD_W'(mag_full[MAG_W-1:0]) * PROD_W'(RECIP_10);
            end
            S_ROUND:
            begin
                res_reg <= neg_reg ? -quot10 : quot10;
            end
            default:
            begin
                up_reg <= up_reg;
            end
        endcase
        if (out_load)
        begin
            out_ch_reg  <= ch_reg;
            out_val_reg <= res_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_channel   = out_ch_reg;
    assign limited_value = out_val_reg;

endmodule

`default_nettype wire
